/* hdl/tdpt_pkg.sv */
// Package for the trial-division prime test.
// Holds the status record passed from the remainder unit to the sequencer.
// No dependencies.
package tdpt_pkg;

   typedef struct packed {
      logic done;
      logic zero;
   } rem_status_type;

endpackage

/* hdl/tdpt_req_if.sv */
// Request channel of the prime test: valid/ready handshake and the number.
// Depends on nothing.
interface tdpt_req_if #(
   parameter int NUM_WIDTH = 31
);
   logic                 valid;
   logic                 ready;
   logic [NUM_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);
endinterface

/* hdl/tdpt_rsp_if.sv */
// Response channel of the prime test: valid/ready handshake and the verdict.
// Depends on nothing.
interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

/* hdl/tdpt_rem_unit.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg for the status record.
module tdpt_rem_unit #(
   parameter int NUM_WIDTH = 31,
   parameter int DIV_WIDTH = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_WIDTH-1:0]    dividend,
   input  logic [DIV_WIDTH-1:0]    divisor,
   output tdpt_pkg::rem_status_type status
);
   localparam int CW = $clog2(NUM_WIDTH + 1);
   localparam logic [CW-1:0] LAST = CW'(NUM_WIDTH - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] shift_ff, shift_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH:0]   trial;

   assign trial = {rem_ff, shift_ff[NUM_WIDTH-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[NUM_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIV_WIDTH'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[DIV_WIDTH-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);
endmodule

/* hdl/trial_division_prime_test.sv */
// Trial-division prime test: 2 and then odd divisors while d*d <= number.
// Numbers below 4 and even numbers are decided on acceptance; for others each odd
// divisor tried takes a bound check and a bit-serial remainder, and a composite stops
// at the first divisor that leaves none. One item at a time; the next item can be
// taken in the cycle after the response is delivered. Synchronous reset clears the
// sequencer and the response valid; no state is kept between items.
module trial_division_prime_test #(
   parameter int NUM_WIDTH = 31
) (
   input logic              clock,
   input logic              reset,
   tdpt_req_if.sink         req_chan,
   tdpt_rsp_if.source       rsp_chan
);
   localparam int DW = (NUM_WIDTH + 1) / 2 + 1;
   localparam int SW = NUM_WIDTH + 2;
   localparam logic [DW-1:0] FIRST_ODD = DW'(3);
   localparam logic [SW-1:0] FIRST_SQ  = SW'(9);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BOUND,
      ST_DIVIDE,
      ST_REPLY
   } state_type;

   state_type                 state_ff;
   logic [NUM_WIDTH-1:0]      num_ff;
   logic [DW-1:0]             div_ff;
   logic [SW-1:0]             sq_ff;
   logic                      prime_ff;
   logic                      start_ff;
   tdpt_pkg::rem_status_type  rem_status;

   tdpt_rem_unit #(
      .NUM_WIDTH(NUM_WIDTH),
      .DIV_WIDTH(DW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (num_ff),
      .divisor  (div_ff),
      .status   (rem_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         start_ff <= (state_ff == ST_BOUND) && (sq_ff <= SW'(num_ff));
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  num_ff <= req_chan.number;
                  div_ff <= FIRST_ODD;
                  sq_ff  <= FIRST_SQ;
                  if (req_chan.number < NUM_WIDTH'(2)) begin
                     prime_ff <= 1'b0;
                     state_ff <= ST_REPLY;
                  end else if (req_chan.number < NUM_WIDTH'(4)) begin
                     prime_ff <= 1'b1;
                     state_ff <= ST_REPLY;
                  end else if (!req_chan.number[0]) begin
                     prime_ff <= 1'b0;
                     state_ff <= ST_REPLY;
                  end else begin
                     state_ff <= ST_BOUND;
                  end
               end
            end
            ST_BOUND: begin
               if (sq_ff > SW'(num_ff)) begin
                  prime_ff <= 1'b1;
                  state_ff <= ST_REPLY;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (rem_status.done) begin
                  if (rem_status.zero) begin
                     prime_ff <= 1'b0;
                     state_ff <= ST_REPLY;
                  end else begin
                     div_ff   <= div_ff + DW'(2);
                     sq_ff    <= sq_ff + SW'({div_ff, 2'b00}) + SW'(4);
                     state_ff <= ST_BOUND;
                  end
               end
            end
            ST_REPLY: begin
               if (rsp_chan.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = (state_ff == ST_REPLY);
   assign rsp_chan.is_prime = prime_ff;
endmodule

/* sim/prime_verdict_checker.sv */
// Checker for the trial-division prime test: watches both channels, works out
// the expected verdict for every accepted number and compares it in order.
// Depends on the tdpt_req_if and tdpt_rsp_if interfaces.
module prime_verdict_checker #(
   parameter int NUM_WIDTH = 31
) (
   input  logic clock,
   input  logic reset,
   tdpt_req_if  req_mon,
   tdpt_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] number;
      logic                 verdict;
   } verdict_entry_type;

   verdict_entry_type expected_verdicts[$];

   function automatic logic prime_verdict(input logic [NUM_WIDTH-1:0] value);
      longint unsigned n;
      longint unsigned divisor;
      n = value;
      if (n < 2) return 1'b0;
      if (n < 4) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (divisor = 3; divisor * divisor <= n; divisor += 2) begin
         if (n % divisor == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      verdict_entry_type entry;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            entry.number  = req_mon.number;
            entry.verdict = prime_verdict(req_mon.number);
            expected_verdicts.push_back(entry);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0b with no item waiting",
                                         rsp_mon.is_prime));
            end else begin
               entry = expected_verdicts.pop_front();
               if (rsp_mon.is_prime !== entry.verdict) begin
                  report_mismatch($sformatf("number %0d: is_prime %0b, expected %0b",
                                            entry.number, rsp_mon.is_prime,
                                            entry.verdict));
               end
            end
         end
      end
      pending_count = expected_verdicts.size();
   end

endmodule

/* sim/testbench.sv */
// Top of the prime test bench: clock, reset, number stimulus and the verdict.
// Drives the block through its interfaces; checking is done by
// prime_verdict_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_WIDTH = 31;

   logic        clock = 1'b0;
   logic        reset;
   int          mismatch_count;
   int          pending_count;
   int          burst_left = 0;
   logic [15:0] ready_pattern = 16'hffff;
   int          pattern_age = 0;

   logic [NUM_WIDTH-1:0] corner_numbers[$] = '{
      0, 1, 2, 3, 4, 5, 7, 8, 9, 15, 25, 49, 97, 121, 65536, 65537, 1022117,
      715827882, 1431655765, 1073741824, 2147483645, 2147483646, 2147483647
   };
   int unsigned small_factors[$] = '{2, 3, 5, 7, 11, 13};

   tdpt_req_if #(.NUM_WIDTH(NUM_WIDTH)) req_chan();
   tdpt_rsp_if rsp_chan();

   trial_division_prime_test #(.NUM_WIDTH(NUM_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   prime_verdict_checker #(.NUM_WIDTH(NUM_WIDTH)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #1 clock = ~clock;

   assign rsp_chan.ready = ready_pattern[0];

   always @(posedge clock) begin
      int unsigned mode;
      if (pattern_age == 0) begin
         mode = $urandom_range(0, 2);
         pattern_age <= $urandom_range(20, 300);
         if (mode == 0) begin
            ready_pattern <= 16'hffff;
         end else if (mode == 1) begin
            ready_pattern <= 16'($urandom) | 16'h0001;
         end else begin
            ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
         end
      end else begin
         pattern_age <= pattern_age - 1;
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   task automatic send_number(input logic [NUM_WIDTH-1:0] value);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
      end
      burst_left--;
      req_chan.valid  <= 1'b1;
      req_chan.number <= value;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      logic [NUM_WIDTH-1:0] value;
      int unsigned          band;
      int unsigned          factor;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.number <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_numbers[i]) send_number(corner_numbers[i]);

      for (int i = 0; i < 77; i++) begin
         band = $urandom_range(0, 19);
         if (band < 8) begin
            value = NUM_WIDTH'($urandom_range(0, 255));
         end else if (band < 13) begin
            value = NUM_WIDTH'($urandom_range(0, 65535));
         end else if (band < 16) begin
            value = NUM_WIDTH'($urandom_range(0, 1048575));
         end else begin
            // Wide numbers keep a small factor so the search ends early.
            value  = NUM_WIDTH'($urandom);
            factor = small_factors[$urandom_range(0, small_factors.size() - 1)];
            value  = value - NUM_WIDTH'(value % factor);
         end
         send_number(value);
      end

      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
